FILE: hw/rtl/rbb_pkg.sv
// shared types, constants and helpers for the rgb box blur block
// no dependencies; imported by every module of the block except rbb_ram
package rbb_pkg;

    localparam int MAX_RADIUS = 7;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int STORE_ROWS = 2 * MAX_RADIUS;
    localparam int WIN_COLS   = 2 * MAX_RADIUS + 1;
    localparam int MEM_DEPTH  = STORE_ROWS * MAX_WIDTH;

    localparam int RAD_W  = 3;
    localparam int DIM_W  = 12;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SLOT_W = $clog2(STORE_ROWS);
    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int CNT_W  = $clog2(WIN_COLS + 1);
    localparam int PIX_W  = 24;
    localparam int CSUM_W = 12;
    localparam int WSUM_W = 16;
    localparam int NUM_W  = WSUM_W + 1;
    localparam int DIV_W  = 9;
    localparam int CFG_W  = 12;
    localparam int QDEPTH = 2;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RADIUS = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] blur_red;
        logic [7:0] blur_green;
        logic [7:0] blur_blue;
        logic       last_of_frame;
    } t_pix_out;

    // clamped configuration seen by the datapath
    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_cfg;

    // classified item passed from front to back
    typedef struct packed {
        t_pix_in           pix;
        logic [DIM_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              in_image;
        logic              col_valid;
        logic              first_col;
        logic              produce;
        logic              last;
    } t_cmd;

    // twice the window area, (2R+1)^2 * 2
    function automatic logic [DIV_W-1:0] win_div(input logic [RAD_W-1:0] rad);
        logic [DIV_W-1:0] side;
        logic [2*DIV_W-1:0] prod;
        side = DIV_W'({rad, 1'b1});
        prod = side * side;
        return DIV_W'({prod[DIV_W-2:0], 1'b0});
    endfunction

endpackage

FILE: hw/rtl/rbb_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module rbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/rbb_front.sv
// front end: tracks the frame position and classifies each input transfer
// depends on rbb_pkg
module rbb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rbb_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  rbb_pkg::t_pix_in i_data,
    input  logic           i_full,
    output logic           o_stall,
    output logic           o_push,
    output rbb_pkg::t_cmd  o_cmd
);
    import rbb_pkg::*;

    logic [DIM_W-1:0]  r_row, n_row;
    logic [DIM_W-1:0]  r_col, n_col;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [DIM_W:0]    col_end, row_end, row_ext, col_ext;
    logic              row_done, frame_done, accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // last fed column and row of the padded frame
    assign col_end = {1'b0, i_cfg.width} + {{(DIM_W-RAD_W+1){1'b0}}, i_cfg.radius} - 1'b1;
    assign row_end = {1'b0, i_cfg.height} + {{(DIM_W-RAD_W+1){1'b0}}, i_cfg.radius} - 1'b1;
    assign row_done   = {1'b0, r_col} >= col_end;
    assign frame_done = {1'b0, r_row} >= row_end;

    // position relative to the window center
    assign row_ext = {1'b0, r_row} - {{(DIM_W-RAD_W+1){1'b0}}, i_cfg.radius};
    assign col_ext = {1'b0, r_col} - {{(DIM_W-RAD_W+1){1'b0}}, i_cfg.radius};

    // classification
    always_comb begin
        o_cmd.pix       = i_data;
        o_cmd.row       = r_row;
        o_cmd.col       = r_col[COL_W-1:0];
        o_cmd.slot      = r_slot;
        o_cmd.col_valid = r_col < i_cfg.width;
        o_cmd.in_image  = (r_row < i_cfg.height) && (r_col < i_cfg.width);
        o_cmd.first_col = r_col == '0;
        o_cmd.produce   = (r_row >= DIM_W'(i_cfg.radius)) && (r_col >= DIM_W'(i_cfg.radius))
                          && (row_ext[DIM_W-1:0] < i_cfg.height)
                          && (col_ext[DIM_W-1:0] < i_cfg.width);
        o_cmd.last      = row_done && frame_done;
    end
    assign o_push = accept;

    // position and store slot update
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_slot = r_slot;
        if (accept) begin
            if (row_done) begin
                n_col = '0;
                if (frame_done) begin
                    n_row  = '0;
                    n_slot = '0;
                end else begin
                    n_row  = r_row + 1'b1;
                    n_slot = (r_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : r_slot + 1'b1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
        end
    end
endmodule

FILE: hw/rtl/rbb_queue.sv
// short command queue between front and back end
// depends on rbb_pkg
module rbb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rbb_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rbb_pkg::t_cmd o_cmd
);
    import rbb_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    t_cmd               r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [PTR_W:0]     r_cnt;

    assign o_full  = r_cnt == (PTR_W+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

FILE: hw/rtl/rbb_back.sv
// back end: column sums from the row store, window sums and rounded division
// depends on rbb_pkg and rbb_ram
module rbb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rbb_pkg::t_cfg   i_cfg,
    input  logic            i_q_valid,
    input  rbb_pkg::t_cmd   i_q_cmd,
    output logic            o_pop,
    output logic            o_valid,
    output rbb_pkg::t_pix_out o_data,
    input  logic            i_stall
);
    import rbb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    localparam int RROW_W = DIM_W + 2;

    t_state               r_state, n_state;
    t_cmd                 r_cmd;
    logic [CNT_W-1:0]     r_j;
    logic [CNT_W-1:0]     iter_cnt;
    logic signed [RROW_W-1:0] r_rrow;
    logic [SLOT_W-1:0]    r_rslot;
    logic                 r_pend;
    logic [CSUM_W-1:0]    r_cs  [3];
    logic [WSUM_W-1:0]    r_ws  [3];
    logic [CSUM_W-1:0]    r_win [WIN_COLS][3];
    logic [NUM_W-1:0]     r_rem [3];
    logic [7:0]           r_q   [3];
    logic [2:0]           r_bit;
    logic                 r_last;
    logic                 r_out_valid;
    t_pix_out             r_out;

    logic [PIX_W-1:0]     rd_data;
    logic [7:0]           rd_ch  [3];
    logic [CSUM_W-1:0]    cs_full [3];
    logic [ADDR_W-1:0]    raddr, waddr;
    logic                 rd_en, wr_en, row_ok;
    logic [SLOT_W:0]      slot_base;
    logic [DIV_W-1:0]     divisor;
    logic [NUM_W-1:0]     trial;
    logic                 out_free;

    assign iter_cnt = CNT_W'({i_cfg.radius, 1'b0});
    assign divisor  = win_div(i_cfg.radius);
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && i_q_valid;

    // row store: one row per slot, columns contiguous
    assign row_ok = (r_rrow >= 0) && (r_rrow < $signed({2'b00, i_cfg.height}))
                    && r_cmd.col_valid;
    assign rd_en  = (r_state == ST_READ) && row_ok;
    assign raddr  = ADDR_W'(r_rslot * MAX_WIDTH) + ADDR_W'(r_cmd.col);
    assign waddr  = ADDR_W'(r_cmd.slot * MAX_WIDTH) + ADDR_W'(r_cmd.col);
    assign wr_en  = (r_state == ST_DRAIN) && r_cmd.in_image;

    rbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (r_cmd.pix),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign rd_ch[0] = rd_data[23:16];
    assign rd_ch[1] = rd_data[15:8];
    assign rd_ch[2] = rd_data[7:0];

    // column sum including the read still in flight
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            cs_full[ch] = r_cs[ch] + (r_pend ? CSUM_W'(rd_ch[ch]) : '0);
        end
    end

    // start slot of the oldest row in the window
    assign slot_base = {1'b0, i_q_cmd.slot} + (SLOT_W+1)'(STORE_ROWS)
                       - (SLOT_W+1)'({i_cfg.radius, 1'b0});

    assign trial = NUM_W'({{(NUM_W-DIV_W){1'b0}}, divisor} << r_bit);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_q_valid) n_state = (iter_cnt == '0) ? ST_DRAIN : ST_READ;
            ST_READ:  if (r_j == iter_cnt - 1'b1) n_state = ST_DRAIN;
            ST_DRAIN: n_state = r_cmd.produce ? ST_DIV : ST_IDLE;
            ST_DIV:   if (r_bit == '0) n_state = ST_EMIT;
            ST_EMIT:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    r_cmd   <= i_q_cmd;
                    r_j     <= '0;
                    r_pend  <= 1'b0;
                    r_rrow  <= $signed({2'b00, i_q_cmd.row})
                               - $signed(RROW_W'({i_cfg.radius, 1'b0}));
                    r_rslot <= (slot_base >= (SLOT_W+1)'(STORE_ROWS))
                               ? SLOT_W'(slot_base - (SLOT_W+1)'(STORE_ROWS))
                               : slot_base[SLOT_W-1:0];
                    r_cs[0] <= i_q_cmd.in_image ? CSUM_W'(i_q_cmd.pix.red)   : '0;
                    r_cs[1] <= i_q_cmd.in_image ? CSUM_W'(i_q_cmd.pix.green) : '0;
                    r_cs[2] <= i_q_cmd.in_image ? CSUM_W'(i_q_cmd.pix.blue)  : '0;
                    for (int ch = 0; ch < 3; ch++) r_ws[ch] <= '0;
                end
            end
            ST_READ: begin
                // one stored row and one older window column per cycle
                r_j     <= r_j + 1'b1;
                r_rrow  <= r_rrow + $signed(RROW_W'(1));
                r_rslot <= (r_rslot == SLOT_W'(STORE_ROWS - 1)) ? '0 : r_rslot + 1'b1;
                r_pend  <= row_ok;
                for (int ch = 0; ch < 3; ch++) begin
                    r_cs[ch] <= cs_full[ch];
                    if (!r_cmd.first_col) begin
                        r_ws[ch] <= r_ws[ch] + WSUM_W'(r_win[r_j[SLOT_W-1:0]][ch]);
                    end
                end
            end
            ST_DRAIN: begin
                // shift the window and form the rounded numerators
                for (int k = WIN_COLS - 1; k > 0; k--) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        r_win[k][ch] <= r_cmd.first_col ? '0 : r_win[k-1][ch];
                    end
                end
                for (int ch = 0; ch < 3; ch++) begin
                    r_win[0][ch] <= cs_full[ch];
                    r_rem[ch] <= NUM_W'({r_ws[ch] + WSUM_W'(cs_full[ch]), 1'b0})
                                 + NUM_W'(divisor[DIV_W-1:1]);
                    r_q[ch]   <= '0;
                end
                r_bit  <= 3'd7;
                r_last <= r_cmd.last;
                r_pend <= 1'b0;
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                r_bit <= r_bit - 1'b1;
                for (int ch = 0; ch < 3; ch++) begin
                    if (r_rem[ch] >= trial) begin
                        r_rem[ch]       <= r_rem[ch] - trial;
                        r_q[ch][r_bit]  <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_out.blur_red      <= r_q[0];
            r_out.blur_green    <= r_q[1];
            r_out.blur_blue     <= r_q[2];
            r_out.last_of_frame <= r_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
endmodule

FILE: hw/rtl/rgb_box_blur_zero_pad_top.sv
// rgb box blur, zero padded: each input transfer is queued; the back end then reads
// 2R stored rows, drains and, for an item with a result, runs 8 division steps and emits
// the back end takes a new item only once it is through with the last one, bound by
// the single read port of the row store and the bit serial divider
// reset is synchronous: position, queue, sequencer cleared, config to radius 1, 640 x 480
// depends on rbb_pkg, rbb_front, rbb_queue, rbb_back, rbb_ram
module rgb_box_blur_zero_pad_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [rbb_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    input  rbb_pkg::t_pix_in           i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output rbb_pkg::t_pix_out          o_data,
    input  logic                       i_stall
);
    import rbb_pkg::*;

    logic [RAD_W-1:0] r_radius;
    logic [DIM_W-1:0] r_width, r_height;
    t_cfg             cfg;
    logic             q_full, q_push, q_valid, q_pop;
    t_cmd             f_cmd, q_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RAD_W'(1);
            r_width  <= DIM_W'(640);
            r_height <= DIM_W'(480);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp to the supported range
    always_comb begin
        cfg.radius = (r_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_radius;
        cfg.width  = (r_width == '0) ? DIM_W'(1)
                   : (r_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_width;
        cfg.height = (r_height == '0) ? DIM_W'(1)
                   : (r_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_height;
    end

    rbb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    rbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    rbb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );
endmodule

FILE: sim/rbb_checker.sv
// transfer monitor and predictor for the rgb box blur block
// watches the config port and both streaming channels, predicts each blurred pixel
// depends on rbb_pkg
module rbb_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [rbb_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_valid,
    input  rbb_pkg::t_pix_in          i_data,
    input  logic                      o_stall,
    input  logic                      o_valid,
    input  rbb_pkg::t_pix_out         o_data,
    input  logic                      i_stall,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import rbb_pkg::*;

    localparam int N_SLOTS = 2 * MAX_RADIUS;
    localparam int N_COLS  = 2 * MAX_RADIUS + 1;

    // predictor state
    logic [23:0]   line_rows [0:N_SLOTS*MAX_WIDTH-1];
    logic [11:0]   col_sums [0:N_COLS-1][0:2];
    logic [11:0]   row_pos;
    logic [11:0]   col_pos;
    logic [2:0]    cfg_radius;
    logic [11:0]   cfg_width;
    logic [11:0]   cfg_height;
    t_pix_out      blurred_q[$];
    int            fails;
    int            results;

    // advance the window by one input transfer, queue the blurred pixel if any
    task automatic blur_step(input t_pix_in px);
        int         rad, wd, ht, r, c, first, s, n, k, ch;
        logic [11:0] cs [0:2];
        logic [23:0] e;
        logic [7:0]  mean [0:2];
        t_pix_out   res;
        bit         in_image;
        rad = cfg_radius;
        wd = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
        ht = (cfg_height == 0) ? 1 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height);
        r = row_pos;
        c = col_pos;
        in_image = (r < ht) && (c < wd);
        cs[0] = in_image ? px.red : 0;
        cs[1] = in_image ? px.green : 0;
        cs[2] = in_image ? px.blue : 0;
        // left padding: each row starts with an empty window
        if (c == 0) begin
            for (k = 0; k < N_COLS; k++)
                for (ch = 0; ch < 3; ch++) col_sums[k][ch] = '0;
        end
        // column sum over the rows above, read before this row is stored
        if (c < wd) begin
            first = (r > 2 * rad) ? r - 2 * rad : 0;
            for (int rr = first; rr < r; rr++) begin
                if (rr < ht) begin
                    e = line_rows[(rr % N_SLOTS) * MAX_WIDTH + c];
                    cs[0] += e[23:16];
                    cs[1] += e[15:8];
                    cs[2] += e[7:0];
                end
            end
        end
        if (in_image) line_rows[(r % N_SLOTS) * MAX_WIDTH + c] = px;
        for (k = N_COLS - 1; k > 0; k--)
            for (ch = 0; ch < 3; ch++) col_sums[k][ch] = col_sums[k-1][ch];
        for (ch = 0; ch < 3; ch++) col_sums[0][ch] = cs[ch];
        // window complete: rounded mean per channel
        if (r >= rad && c >= rad && r - rad < ht && c - rad < wd) begin
            n = (2 * rad + 1) * (2 * rad + 1);
            for (ch = 0; ch < 3; ch++) begin
                s = 0;
                for (k = 0; k <= 2 * rad; k++) s += col_sums[k][ch];
                mean[ch] = 8'((2 * s + n) / (2 * n));
            end
            res.blur_red      = mean[0];
            res.blur_green    = mean[1];
            res.blur_blue     = mean[2];
            res.last_of_frame = (r >= ht + rad - 1) && (c >= wd + rad - 1);
            blurred_q.push_back(res);
        end
        // raster position with wrap at the end of the fed frame
        if (c >= wd + rad - 1) begin
            col_pos = '0;
            row_pos = (r >= ht + rad - 1) ? 12'd0 : 12'(r + 1);
        end else begin
            col_pos = 12'(c + 1);
        end
    endtask

    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            row_pos = '0;
            col_pos = '0;
            cfg_radius = 3'd1;
            cfg_width = 12'd640;
            cfg_height = 12'd480;
            for (int k = 0; k < N_COLS; k++)
                for (int ch = 0; ch < 3; ch++) col_sums[k][ch] = '0;
            blurred_q.delete();
        end else begin
            // an input transfer sees the registers as they were before this edge
            if (i_valid && !o_stall) blur_step(i_data);
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_RADIUS: cfg_radius = i_cfg_data[2:0];
                    CFG_WIDTH:  cfg_width = i_cfg_data;
                    CFG_HEIGHT: cfg_height = i_cfg_data;
                    default: ;
                endcase
            end
            // compare each output transfer with the oldest prediction
            if (o_valid && !i_stall) begin
                results++;
                if (blurred_q.size() == 0) begin
                    $error("unexpected output pixel %h", o_data);
                    fails++;
                end else begin
                    want = blurred_q.pop_front();
                    if (o_data.blur_red !== want.blur_red) begin
                        $error("blur_red: expected %0d, got %0d", want.blur_red, o_data.blur_red);
                        fails++;
                    end
                    if (o_data.blur_green !== want.blur_green) begin
                        $error("blur_green: expected %0d, got %0d",
                               want.blur_green, o_data.blur_green);
                        fails++;
                    end
                    if (o_data.blur_blue !== want.blur_blue) begin
                        $error("blur_blue: expected %0d, got %0d",
                               want.blur_blue, o_data.blur_blue);
                        fails++;
                    end
                    if (o_data.last_of_frame !== want.last_of_frame) begin
                        $error("last_of_frame: expected %0d, got %0d",
                               want.last_of_frame, o_data.last_of_frame);
                        fails++;
                    end
                end
            end
        end
        o_pending <= blurred_q.size();
        o_fail_count <= fails;
        o_result_count <= results;
    end

    initial begin
        fails = 0;
        results = 0;
        o_pending = 0;
        o_fail_count = 0;
        o_result_count = 0;
    end

endmodule

FILE: sim/rgb_box_blur_zero_pad_top_tb.sv
// stimulus and verdict for the rgb box blur block
// drives frames of several sizes and radii; depends on rbb_pkg, rbb_checker and the block
module rgb_box_blur_zero_pad_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbb_pkg::*;

    localparam int SETTLE = 40;
    localparam int DOG_LIMIT = 4000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_valid;
    t_pix_in           i_data;
    logic              o_stall;
    logic              o_valid;
    t_pix_out          o_data;
    logic              i_stall;

    int  fail_count, pending, result_count;
    int  items_sent, frames_run, quiet_cycles;
    bit  no_idle;

    rgb_box_blur_zero_pad_top uut (.*);

    rbb_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_data, .o_stall, .o_valid, .o_data, .i_stall,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // output side: random stall before each transfer
    initial begin
        int n;
        i_stall = 1'b1;
        @(posedge i_clk);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 18);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= DOG_LIMIT) begin
            $display("rgb_box_blur_zero_pad_top_tb NOT OK");
            $finish;
        end
    end

    // one register write; the caller drops the write enable after the last one
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // one pixel transfer after a random gap
    task automatic send_pixel(input t_pix_in px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // whole fed frame: (H+R) rows of (W+R) items, then drain before the next setup
    task automatic run_frame(input int rad, input int wd, input int ht, input bit directed);
        int cw, chh, total;
        t_pix_in px;
        write_reg(CFG_RADIUS, CFG_W'(rad));
        write_reg(CFG_WIDTH, CFG_W'(wd));
        write_reg(CFG_HEIGHT, CFG_W'(ht));
        i_cfg_we <= 1'b0;
        cw = (wd == 0) ? 1 : ((wd > MAX_WIDTH) ? MAX_WIDTH : wd);
        chh = (ht == 0) ? 1 : ((ht > MAX_HEIGHT) ? MAX_HEIGHT : ht);
        total = (chh + rad) * (cw + rad);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < total; k++) begin
            if (directed) begin
                px.red = k[0] ? 8'hFF : 8'h00;
                px.green = (k % 3 == 0) ? 8'hAA : 8'h55;
                px.blue = 8'(k * 37);
            end else begin
                px.red = pick_level();
                px.green = pick_level();
                px.blue = pick_level();
            end
            send_pixel(px);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        frames_run++;
    endtask

    initial begin
        int rad, wd, ht;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_RADIUS;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_data = '0;
        no_idle = 1'b0;
        items_sent = 0;
        frames_run = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: small blur, pass-through, widest window, zero dimensions
        run_frame(1, 3, 2, 1'b1);
        run_frame(0, 4, 1, 1'b1);
        run_frame(7, 1, 1, 1'b0);
        run_frame(7, 0, 0, 1'b0);

        // random frames, all small
        while (items_sent < 1550) begin
            rad = $urandom_range(0, 7);
            wd = $urandom_range(1, 14);
            ht = $urandom_range(1, 10);
            run_frame(rad, wd, ht, 1'b0);
        end

        $display("ran %0d frames, %0d pixels in, %0d blurred pixels checked",
                 frames_run, items_sent, result_count);
        if (fail_count == 0) begin
            $display("rgb_box_blur_zero_pad_top_tb OK");
        end else begin
            $display("rgb_box_blur_zero_pad_top_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/rbb_pkg.sv
hw/rtl/rbb_ram.sv
hw/rtl/rbb_front.sv
hw/rtl/rbb_queue.sv
hw/rtl/rbb_back.sv
hw/rtl/rgb_box_blur_zero_pad_top.sv
sim/rbb_checker.sv
sim/rgb_box_blur_zero_pad_top_tb.sv
